/* rtl/edt_pkg.sv */
package edt_pkg;

    // storage geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int COL_W       = $clog2(MAX_WIDTH);

    // field widths
    localparam int COORD_W    = 8;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 16;
    localparam int SIZE_W     = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd3;

    // kernel modes
    localparam logic [MODE_W-1:0] KMODE_LAPLACE = 2'd0;
    localparam logic [MODE_W-1:0] KMODE_VERT    = 2'd1;
    localparam logic [MODE_W-1:0] KMODE_HORZ    = 2'd2;

    // frame limits and kernel choice handed to the sequencer
    typedef struct packed {
        logic [ROW_W-1:0]  row_last;
        logic [COL_W-1:0]  col_last;
        logic [MODE_W-1:0] mode;
    } edt_cfg_t;

    // finished kernel sum waiting for the output stage
    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] sum;
    } edt_acc_t;

    // single frame memory port request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } edt_ram_req_t;

endpackage

/* rtl/edt_if.sv */
// command beats: pixel write or edge query
interface edt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [edt_pkg::COORD_W-1:0]   row;
    logic [edt_pkg::COORD_W-1:0]   col;
    logic [edt_pkg::PIX_W-1:0]     pixel_value;

    modport source (output valid, command, row, col, pixel_value, input ready);
    modport sink (input valid, command, row, col, pixel_value, output ready);
endinterface

// result beats: one per query
interface edt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [edt_pkg::SUM_W-1:0] filter_sum;
    logic                          is_edge;
    logic [edt_pkg::CNT_W-1:0]     edge_total;

    modport source (output valid, filter_sum, is_edge, edge_total, input ready);
    modport sink (input valid, filter_sum, is_edge, edge_total, output ready);
endinterface

// register write beats
interface edt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [edt_pkg::CFG_IDX_W-1:0]   index;
    logic [edt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/edt_frame_ram.sv */
module edt_frame_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* rtl/edt_query_seq.sv */
module edt_query_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    edt_req_if.sink                      req,
    input  edt_pkg::edt_cfg_t            cfg,
    output edt_pkg::edt_ram_req_t        ram_req,
    input  logic [edt_pkg::PIX_W-1:0]    ram_rdata,
    output edt_pkg::edt_acc_t            acc,
    input  logic                         take
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } seq_state_t;

    localparam logic [1:0] TAP_LAST = 2'd2;
    localparam logic [1:0] TAP_MID  = 2'd1;
    localparam int         COEF_W   = 5;

    seq_state_t state_reg, state_next;
    logic [1:0] ri_reg, ri_next;
    logic [1:0] ci_reg, ci_next;
    logic [edt_pkg::ROW_W-1:0] r_reg [3];
    logic [edt_pkg::COL_W-1:0] c_reg [3];
    logic signed [edt_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic rd_pend_reg;
    logic signed [COEF_W-1:0] coef_reg, coef_cur;

    logic accept;
    logic wr_hit;
    logic signed [edt_pkg::SUM_W-1:0] pix_s, coef_s, prod;

    // kernel coefficient at tap (ri, ci); unused mode acts as laplacian
    function automatic logic signed [COEF_W-1:0] kernel_coef(
        input logic [edt_pkg::MODE_W-1:0] mode,
        input logic [1:0]                 ri,
        input logic [1:0]                 ci
    );
        logic signed [COEF_W-1:0] k;
        k = -5'sd1;
        case (mode)
            edt_pkg::KMODE_VERT:
            begin
                if (ci == TAP_MID)
                    k = 5'sd0;
                else if (ci == TAP_LAST)
                    k = 5'sd1;
            end
            edt_pkg::KMODE_HORZ:
            begin
                if (ri == TAP_MID)
                    k = 5'sd0;
                else if (ri == TAP_LAST)
                    k = 5'sd1;
            end
            default:
            begin
                if (ri == TAP_MID && ci == TAP_MID)
                    k = 5'sd8;
            end
        endcase
        return k;
    endfunction

    // clamp one neighbour coordinate into [0, last]
    function automatic int clamp_coord(input int v, input int last);
        int r;
        if (v < 0)
            r = 0;
        else if (v > last)
            r = last;
        else
            r = v;
        return r;
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign wr_hit    = accept && (req.command == edt_pkg::CMD_WRITE)
                       && (int'(req.row) < edt_pkg::MAX_HEIGHT)
                       && (int'(req.col) < edt_pkg::MAX_WIDTH);

    assign coef_cur = kernel_coef(cfg.mode, ri_reg, ci_reg);

    // memory port: pixel write on accept, neighbourhood reads while scanning
    always_comb
    begin
        ram_req.en    = wr_hit || (state_reg == S_READ);
        ram_req.we    = wr_hit;
        ram_req.wdata = req.pixel_value;
        if (state_reg == S_READ)
            ram_req.addr = edt_pkg::ADDR_W'(int'(r_reg[ri_reg]) * edt_pkg::MAX_WIDTH
                                            + int'(c_reg[ci_reg]));
        else
            ram_req.addr = edt_pkg::ADDR_W'(int'(req.row) * edt_pkg::MAX_WIDTH
                                            + int'(req.col));
    end

    // product of returned pixel and its tap coefficient
    assign pix_s  = edt_pkg::SUM_W'(ram_rdata);
    assign coef_s = edt_pkg::SUM_W'(coef_reg);
    assign prod   = pix_s * coef_s;

    // tap scan and accumulate
    always_comb
    begin
        state_next = state_reg;
        ri_next    = ri_reg;
        ci_next    = ci_reg;
        sum_next   = sum_reg;
        if (rd_pend_reg)
            sum_next = sum_reg + prod;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.command == edt_pkg::CMD_QUERY)
                begin
                    state_next = S_READ;
                    ri_next    = 2'd0;
                    ci_next    = 2'd0;
                    sum_next   = '0;
                end
            end
            S_READ:
            begin
                if (ci_reg == TAP_LAST)
                begin
                    ci_next = 2'd0;
                    if (ri_reg == TAP_LAST)
                        state_next = S_LAST;
                    else
                        ri_next = ri_reg + 2'd1;
                end
                else
                begin
                    ci_next = ci_reg + 2'd1;
                end
            end
            S_LAST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign acc.done = (state_reg == S_DONE);
    assign acc.sum  = sum_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_READ);
        end
    end

    // scan position, clamped neighbourhood and running sum
    always_ff @(posedge clk)
    begin
        ri_reg   <= ri_next;
        ci_reg   <= ci_next;
        sum_reg  <= sum_next;
        coef_reg <= coef_cur;
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k] <= edt_pkg::ROW_W'(clamp_coord(int'(req.row) + k - 1,
                                                        int'(cfg.row_last)));
                c_reg[k] <= edt_pkg::COL_W'(clamp_coord(int'(req.col) + k - 1,
                                                        int'(cfg.col_last)));
            end
        end
    end

endmodule

/* rtl/edge_detect_3x3_threshold_unit.sv */
// 3x3 edge detector over a stored gray frame, one single-port frame memory.
// pixel write: written to memory at the edge that accepts it.
// query: nine memory reads, one per cycle, then accumulate and hand-off; the sum moves into
//   the output register when taken, and the next command is accepted once the sequencer is idle.
// results sit in an output register, so writes keep flowing while one waits.
// reset clears the edge counter and loads register defaults; frame memory is not cleared.
module edge_detect_3x3_threshold_unit (
    input  logic    clk,
    input  logic    rst_n,
    edt_req_if.sink req,
    edt_rsp_if.source rsp,
    edt_cfg_if.sink cfg
);

    localparam logic [edt_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic [edt_pkg::SIZE_W-1:0]        frame_width_reg;
    logic [edt_pkg::SIZE_W-1:0]        frame_height_reg;
    logic [edt_pkg::MODE_W-1:0]        kernel_mode_reg;
    logic signed [edt_pkg::SUM_W-1:0]  edge_threshold_reg;
    logic [edt_pkg::CNT_W-1:0]         edge_cnt_reg, edge_cnt_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [edt_pkg::SUM_W-1:0]  out_sum_reg;
    logic                              out_edge_reg;
    logic [edt_pkg::CNT_W-1:0]         out_total_reg;

    edt_pkg::edt_cfg_t     seq_cfg;
    edt_pkg::edt_ram_req_t ram_req;
    edt_pkg::edt_acc_t     acc;
    logic [edt_pkg::PIX_W-1:0] ram_rdata;
    logic take;
    logic edge_hit;

    // effective frame limits, sizes bounded to [1, max]
    function automatic int bound_size(input int v, input int maxv);
        int r;
        if (v < 1)
            r = 1;
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    assign seq_cfg.row_last = edt_pkg::ROW_W'(bound_size(int'(frame_height_reg),
                                                         edt_pkg::MAX_HEIGHT) - 1);
    assign seq_cfg.col_last = edt_pkg::COL_W'(bound_size(int'(frame_width_reg),
                                                         edt_pkg::MAX_WIDTH) - 1);
    assign seq_cfg.mode     = kernel_mode_reg;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= 9'd256;
            frame_height_reg   <= 9'd256;
            kernel_mode_reg    <= edt_pkg::KMODE_LAPLACE;
            edge_threshold_reg <= 12'sd240;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                edt_pkg::REG_FRAME_WIDTH:    frame_width_reg    <= cfg.data[edt_pkg::SIZE_W-1:0];
                edt_pkg::REG_FRAME_HEIGHT:   frame_height_reg   <= cfg.data[edt_pkg::SIZE_W-1:0];
                edt_pkg::REG_KERNEL_MODE:    kernel_mode_reg    <= cfg.data[edt_pkg::MODE_W-1:0];
                edt_pkg::REG_EDGE_THRESHOLD: edge_threshold_reg <= $signed(cfg.data);
                default:
                begin
                end
            endcase
        end
    end

    edt_frame_ram #(
        .DATA_W (edt_pkg::PIX_W),
        .DEPTH  (edt_pkg::STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    edt_query_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (seq_cfg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .acc       (acc),
        .take      (take)
    );

    // threshold, counter and output register
    assign take     = acc.done && (!out_valid_reg || rsp.ready);
    assign edge_hit = (acc.sum >= edge_threshold_reg);

    always_comb
    begin
        edge_cnt_next  = edge_cnt_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (edge_hit && edge_cnt_reg != CNT_MAX)
                edge_cnt_next = edge_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            edge_cnt_reg  <= edge_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_sum_reg   <= acc.sum;
            out_edge_reg  <= edge_hit;
            out_total_reg <= edge_cnt_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.filter_sum = out_sum_reg;
    assign rsp.is_edge    = out_edge_reg;
    assign rsp.edge_total = out_total_reg;

    // no new command while a finished sum is held
    a_no_accept_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        acc.done |-> !req.ready)
        else $error("command port open while a result is held");

    // counter holds once full
    a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_cnt_reg == CNT_MAX) |=> (edge_cnt_reg == CNT_MAX))
        else $error("edge counter wrapped");

    // an edge hit below full bumps the counter by one
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && edge_hit && edge_cnt_reg != CNT_MAX)
        |=> (edge_cnt_reg == $past(edge_cnt_reg) + 1'b1))
        else $error("edge counter missed an edge");

endmodule
